// ----- rtl/gb2fa_pkg.sv -----
// ----------------------------------------------------------------------------
// gb2fa_pkg
// Shared types and constants for the GB2312 text to font address decoder.
// ----------------------------------------------------------------------------
package gb2fa_pkg;

    // Font mode register
    localparam int FONT_MODE_W = 2;
    localparam logic [FONT_MODE_W-1:0] MODE_ASCII_A = 2'd0;
    localparam logic [FONT_MODE_W-1:0] MODE_ASCII_B = 2'd1;
    localparam logic [FONT_MODE_W-1:0] MODE_5X7     = 2'd2;

    // Glyph kinds
    localparam logic [1:0] KIND_HANZI  = 2'd0;
    localparam logic [1:0] KIND_SYMBOL = 2'd1;
    localparam logic [1:0] KIND_A8X16  = 2'd2;
    localparam logic [1:0] KIND_A5X7   = 2'd3;

    // Font ROM bases and layout
    localparam logic [23:0] BASE_ASCII_A = 24'h03CF80;
    localparam logic [23:0] BASE_ASCII_B = 24'h03B7C0;
    localparam logic [23:0] BASE_5X7     = 24'h03BFC0;
    localparam logic [6:0]  ROW_LEN      = 7'd94;
    localparam logic [12:0] HANZI_OFFSET = 13'd846;

    // Byte code ranges
    localparam logic [7:0] HANZI_LEAD_LO = 8'hB0;
    localparam logic [7:0] HANZI_LEAD_HI = 8'hF7;
    localparam logic [7:0] SYM_LEAD_LO   = 8'hA1;
    localparam logic [7:0] SYM_LEAD_HI   = 8'hA3;
    localparam logic [7:0] TRAIL_LO      = 8'hA1;
    localparam logic [7:0] HANZI_TRAIL_HI = 8'hFE;
    localparam logic [7:0] ASCII_LO      = 8'h20;
    localparam logic [7:0] ASCII_HI      = 8'h7E;
    localparam logic [7:0] TERMINATOR    = 8'h00;

    // Byte counts and cursor advances
    localparam logic [5:0] COUNT_WIDE  = 6'd32;
    localparam logic [5:0] COUNT_A8X16 = 6'd16;
    localparam logic [5:0] COUNT_A5X7  = 6'd8;
    localparam logic [7:0] ADV_WIDE    = 8'd16;
    localparam logic [7:0] ADV_A8X16   = 8'd8;
    localparam logic [7:0] ADV_A5X7    = 8'd6;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       start_req;
        logic [2:0] start_row;
        logic [7:0] start_column;
    } text_item_t;

    typedef struct packed {
        logic [23:0] rom_address;
        logic [1:0]  glyph_kind;
        logic [5:0]  byte_count;
        logic [7:0]  column;
        logic [2:0]  page;
    } glyph_item_t;

    typedef struct packed {
        logic [7:0] pending_lead;
        logic       pending_valid;
        logic [7:0] cursor_column;
        logic [2:0] cursor_page;
        logic       string_active;
    } dec_state_t;

endpackage

// ----- rtl/gb2fa_text_if.sv -----
// ----------------------------------------------------------------------------
// gb2fa_text_if
// Text byte channel: valid/ready handshake with one string byte per transfer.
// ----------------------------------------------------------------------------
interface gb2fa_text_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       start_req;
    logic [2:0] start_row;
    logic [7:0] start_column;

    modport source (output valid, output text_byte, output start_req,
                    output start_row, output start_column, input ready);
    modport sink   (input valid, input text_byte, input start_req,
                    input start_row, input start_column, output ready);
endinterface

// ----- rtl/gb2fa_glyph_if.sv -----
// ----------------------------------------------------------------------------
// gb2fa_glyph_if
// Glyph channel: valid/ready handshake with one font fetch request per transfer.
// ----------------------------------------------------------------------------
interface gb2fa_glyph_if;
    logic        valid;
    logic        ready;
    logic [23:0] rom_address;
    logic [1:0]  glyph_kind;
    logic [5:0]  byte_count;
    logic [7:0]  column;
    logic [2:0]  page;

    modport source (output valid, output rom_address, output glyph_kind,
                    output byte_count, output column, output page, input ready);
    modport sink   (input valid, input rom_address, input glyph_kind,
                    input byte_count, input column, input page, output ready);
endinterface

// ----- rtl/gb2fa_decode.sv -----
// ----------------------------------------------------------------------------
// gb2fa_decode
// Combinational byte decoder: next cursor/lead state and the glyph, if any.
// ----------------------------------------------------------------------------
module gb2fa_decode
    import gb2fa_pkg::*;
(
    input  text_item_t              item,
    input  dec_state_t              state,
    input  logic [FONT_MODE_W-1:0]  font_mode,
    output dec_state_t              state_next,
    output logic                    emit,
    output glyph_item_t             glyph
);

    dec_state_t  s;
    logic [7:0]  b;
    logic [7:0]  lead;
    logic        b_ascii;
    logic        b_lead;
    logic        lead_hanzi;
    logic        lead_symbol;
    logic        hit_hanzi;
    logic        hit_symbol;
    logic [6:0]  row;
    logic [6:0]  col;
    logic [12:0] row_base;
    logic [12:0] glyph_index;
    logic [6:0]  ascii_off;
    logic [7:0]  advance;

    always_comb
    begin
        s = state;
        if (item.start_req)
        begin
            s.cursor_column = item.start_column;
            s.cursor_page   = item.start_row;
            s.pending_valid = 1'b0;
            s.pending_lead  = '0;
            s.string_active = 1'b1;
        end
    end

    assign b    = item.text_byte;
    assign lead = s.pending_lead;

    assign b_ascii     = (b >= ASCII_LO) && (b <= ASCII_HI);
    assign b_lead      = ((b >= HANZI_LEAD_LO) && (b <= HANZI_LEAD_HI))
                      || ((b >= SYM_LEAD_LO) && (b <= SYM_LEAD_HI));
    assign lead_hanzi  = (lead >= HANZI_LEAD_LO) && (lead <= HANZI_LEAD_HI);
    assign lead_symbol = (lead >= SYM_LEAD_LO) && (lead <= SYM_LEAD_HI);
    assign hit_hanzi   = s.pending_valid && lead_hanzi
                      && (b >= TRAIL_LO) && (b <= HANZI_TRAIL_HI);
    assign hit_symbol  = s.pending_valid && lead_symbol && (b >= TRAIL_LO);

    // One shared row multiply for both pair kinds
    always_comb
    begin
        row = lead_hanzi ? 7'(lead - HANZI_LEAD_LO) : 7'(lead - SYM_LEAD_LO);
        col = 7'(b - TRAIL_LO);
    end

    assign row_base    = 13'(row) * 13'(ROW_LEN);
    assign glyph_index = row_base + 13'(col) + (lead_hanzi ? HANZI_OFFSET : 13'd0);
    assign ascii_off   = 7'(b - ASCII_LO);

    always_comb
    begin
        state_next = s;
        emit       = 1'b0;
        advance    = '0;
        glyph.rom_address = {6'd0, glyph_index, 5'd0};
        glyph.glyph_kind  = KIND_HANZI;
        glyph.byte_count  = COUNT_WIDE;
        glyph.column      = s.cursor_column;
        glyph.page        = s.cursor_page;

        if (!s.string_active)
        begin
            state_next = s;
        end
        else if (b == TERMINATOR)
        begin
            state_next.pending_valid = 1'b0;
            state_next.pending_lead  = '0;
            state_next.string_active = 1'b0;
        end
        else if (font_mode[1])
        begin
            state_next.pending_valid = 1'b0;
            state_next.pending_lead  = '0;
            if (b_ascii)
            begin
                emit    = 1'b1;
                advance = ADV_A5X7;
                glyph.rom_address = {14'd0, ascii_off, 3'd0} + BASE_5X7;
                glyph.glyph_kind  = KIND_A5X7;
                glyph.byte_count  = COUNT_A5X7;
            end
        end
        else
        begin
            state_next.pending_valid = 1'b0;
            state_next.pending_lead  = '0;
            if (hit_hanzi || hit_symbol)
            begin
                emit    = 1'b1;
                advance = ADV_WIDE;
                glyph.glyph_kind = hit_hanzi ? KIND_HANZI : KIND_SYMBOL;
            end
            else if (b_lead)
            begin
                state_next.pending_valid = 1'b1;
                state_next.pending_lead  = b;
            end
            else if (b_ascii)
            begin
                emit    = 1'b1;
                advance = ADV_A8X16;
                glyph.rom_address = {13'd0, ascii_off, 4'd0}
                                  + ((font_mode == MODE_ASCII_B) ? BASE_ASCII_B
                                                                 : BASE_ASCII_A);
                glyph.glyph_kind  = KIND_A8X16;
                glyph.byte_count  = COUNT_A8X16;
            end
        end

        state_next.cursor_column = s.cursor_column + advance;
    end

endmodule

// ----- rtl/gb2312_text_to_font_address.sv -----
// ----------------------------------------------------------------------------
// gb2312_text_to_font_address
// Decodes a GB2312/ASCII text byte stream into font ROM fetch requests.
// Path: a text byte passes the input register, the decoder and the output register.
// Throughput: one text byte per cycle while the glyph output is not stalled;
// the lead/cursor state loop closes through the single decode stage between
// input and result registers.
// Reset: asynchronous, active low; empties both registers, clears the cursor,
// held lead and open-string flag, and sets the font mode to 0.
// ----------------------------------------------------------------------------
module gb2312_text_to_font_address
    import gb2fa_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    font_mode_we,
    input  logic [FONT_MODE_W-1:0]  font_mode_wdata,
    gb2fa_text_if.sink              text,
    gb2fa_glyph_if.source           glyph
);

    logic [FONT_MODE_W-1:0] font_mode_reg;

    // Input stage: one captured text byte
    logic        in_valid_reg;
    text_item_t  in_item_reg;

    // Decoder state loop
    dec_state_t  state_reg;
    dec_state_t  state_next;

    // Result stage
    logic        out_valid_reg;
    glyph_item_t out_item_reg;

    logic        dec_emit;
    glyph_item_t dec_glyph;
    logic        advance;
    logic        out_load;

    // Retire the captured byte once the result register can take its glyph
    assign advance  = in_valid_reg && (!out_valid_reg || glyph.ready);
    assign out_load = advance && dec_emit;

    // Accept a new byte whenever the input stage is empty or retiring
    assign text.ready = !in_valid_reg || advance;

    // The user must write font mode only while the block is idle; the block does not enforce it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            font_mode_reg <= MODE_ASCII_A;
        end
        else if (font_mode_we)
        begin
            font_mode_reg <= font_mode_wdata;
        end
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (text.ready)
        begin
            in_valid_reg <= text.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (text.valid && text.ready)
        begin
            in_item_reg.text_byte    <= text.text_byte;
            in_item_reg.start_req    <= text.start_req;
            in_item_reg.start_row    <= text.start_row;
            in_item_reg.start_column <= text.start_column;
        end
    end

    gb2fa_decode u_decode (
        .item       (in_item_reg),
        .state      (state_reg),
        .font_mode  (font_mode_reg),
        .state_next (state_next),
        .emit       (dec_emit),
        .glyph      (dec_glyph)
    );

    // Commit the cursor and held lead only when the byte retires
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else if (advance)
        begin
            state_reg <= state_next;
        end
    end

    // Result register: hold while stalled, drop after transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (glyph.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_item_reg <= dec_glyph;
        end
    end

    assign glyph.valid       = out_valid_reg;
    assign glyph.rom_address = out_item_reg.rom_address;
    assign glyph.glyph_kind  = out_item_reg.glyph_kind;
    assign glyph.byte_count  = out_item_reg.byte_count;
    assign glyph.column      = out_item_reg.column;
    assign glyph.page        = out_item_reg.page;

endmodule

// ----- rtl/gb2fa_checker.sv -----
// ----------------------------------------------------------------------------
// gb2fa_checker
// Port-level checks on the glyph channel of the text to font address decoder.
// ----------------------------------------------------------------------------
module gb2fa_checker
    import gb2fa_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        glyph_valid,
    input  logic        glyph_ready,
    input  logic [23:0] rom_address,
    input  logic [1:0]  glyph_kind,
    input  logic [5:0]  byte_count
);

    // A stalled glyph stays offered
    assert property (@(posedge clk) disable iff (!rst_n)
        glyph_valid && !glyph_ready |=> glyph_valid)
        else $error("glyph transfer withdrawn while stalled");

    // A stalled glyph keeps its address
    assert property (@(posedge clk) disable iff (!rst_n)
        glyph_valid && !glyph_ready |=> $stable(rom_address))
        else $error("glyph address changed while stalled");

    // Byte count follows the glyph kind
    assert property (@(posedge clk) disable iff (!rst_n)
        glyph_valid |-> ((glyph_kind == KIND_A5X7) && (byte_count == COUNT_A5X7))
                     || ((glyph_kind == KIND_A8X16) && (byte_count == COUNT_A8X16))
                     || ((glyph_kind == KIND_HANZI) && (byte_count == COUNT_WIDE))
                     || ((glyph_kind == KIND_SYMBOL) && (byte_count == COUNT_WIDE)))
        else $error("byte count does not match glyph kind");

    // Glyphs sit on an 8-byte (5x7) or 16-byte (all others) boundary inside the 256 KiB font area
    assert property (@(posedge clk) disable iff (!rst_n)
        glyph_valid |-> (rom_address[23:18] == 6'd0)
                     && ((glyph_kind == KIND_A5X7) || (rom_address[3:0] == 4'd0))
                     && (rom_address[2:0] == 3'd0))
        else $error("glyph address misaligned or out of range");

endmodule

bind gb2312_text_to_font_address gb2fa_checker u_gb2fa_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .glyph_valid (glyph.valid),
    .glyph_ready (glyph.ready),
    .rom_address (glyph.rom_address),
    .glyph_kind  (glyph.glyph_kind),
    .byte_count  (glyph.byte_count)
);
